@@ hw/rtl/paq_pkg.sv @@
// ----------------------------------------------------------------------------
// paq_pkg
// Shared types and codes for the pending alarm queue: entry layout, request
// function codes and the per-cycle command that steers the cell chain.
// ----------------------------------------------------------------------------
package paq_pkg;

  localparam int unsigned SeqW   = 16;
  localparam int unsigned KindW  = 8;
  localparam int unsigned CallW  = 8;
  localparam int unsigned FuncW  = 3;
  localparam int unsigned CountW = 5;

  // Request function codes
  localparam logic [FuncW-1:0] FUNC_PUSH     = 3'd0;
  localparam logic [FuncW-1:0] FUNC_REM_SEQ  = 3'd1;
  localparam logic [FuncW-1:0] FUNC_REM_KIND = 3'd2;
  localparam logic [FuncW-1:0] FUNC_POP      = 3'd3;
  localparam logic [FuncW-1:0] FUNC_COUNT    = 3'd4;

  typedef struct packed {
    logic [CallW-1:0] call;
    logic [KindW-1:0] kind;
    logic [SeqW-1:0]  seq;
  } entry_t;

  // What every cell does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD,    // keep contents
    CELL_SHIFT,   // take the upper neighbor (chain moves toward the head)
    CELL_APPEND,  // first free cell takes the pushed entry
    CELL_SORT     // odd-even exchange step that squeezes out holes
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e mode;
    logic       parity;  // which pairs exchange in a sort step
  } cell_ctl_t;

endpackage

@@ hw/rtl/paq_cell.sv @@
// ----------------------------------------------------------------------------
// paq_cell
// One slot of the alarm queue chain: an entry plus a live flag, moved or
// exchanged with its neighbors as the controller commands.
// ----------------------------------------------------------------------------
module paq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  paq_pkg::cell_ctl_t ctl_i,
  input  logic               is_odd_i,
  input  paq_pkg::entry_t    app_entry_i,
  input  paq_pkg::entry_t    up_entry_i,
  input  logic               up_live_i,
  input  logic               low_live_i,
  output paq_pkg::entry_t    entry_o,
  output logic               live_o
);

  paq_pkg::entry_t entry_q, entry_d;
  logic            live_q, live_d;
  logic            pair_up;

  // Lower member of the pair (me, up) when my index parity matches.
  assign pair_up = (is_odd_i == ctl_i.parity);

  always_comb begin
    entry_d = entry_q;
    live_d  = live_q;
    case (ctl_i.mode)
      paq_pkg::CELL_HOLD: begin
      end
      paq_pkg::CELL_SHIFT: begin
        entry_d = up_entry_i;
        live_d  = up_live_i;
      end
      paq_pkg::CELL_APPEND: begin
        if (!live_q && low_live_i) begin
          entry_d = app_entry_i;
          live_d  = 1'b1;
        end
      end
      paq_pkg::CELL_SORT: begin
        if (pair_up) begin
          if (!live_q && up_live_i) begin
            entry_d = up_entry_i;
            live_d  = 1'b1;
          end
        end else if (!low_live_i && live_q) begin
          live_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
    end else begin
      live_q <= live_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign live_o  = live_q;

endmodule

@@ hw/rtl/paq_ctrl.sv @@
// ----------------------------------------------------------------------------
// paq_ctrl
// Request sequencer and head processor: steers the cell chain, inspects the
// entry at the head during a rotation pass, and holds the result register.
// ----------------------------------------------------------------------------
module paq_ctrl #(
  parameter int unsigned MaxEntries = 21
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [paq_pkg::FuncW-1:0]    func_i,
  input  logic [paq_pkg::SeqW-1:0]     seq_number_i,
  input  logic [paq_pkg::KindW-1:0]    alarm_kind_i,
  input  logic [paq_pkg::CallW-1:0]    call_flags_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         found_o,
  output paq_pkg::entry_t              entry_o,
  output logic [paq_pkg::CountW-1:0]   match_count_o,
  input  paq_pkg::entry_t              head_entry_i,
  input  logic                         head_live_i,
  input  logic                         full_i,
  output paq_pkg::cell_ctl_t           cell_ctl_o,
  output paq_pkg::entry_t              tail_entry_o,
  output logic                         tail_live_o,
  output paq_pkg::entry_t              app_entry_o,
  output logic                         idle_o
);

  localparam int unsigned CntW = $clog2(MaxEntries);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_SORT, ST_DONE} state_e;

  state_e                        state_q;
  logic [CntW-1:0]               cnt_q;
  logic [paq_pkg::FuncW-1:0]     func_q;
  logic [paq_pkg::SeqW-1:0]      seq_q;
  logic [paq_pkg::KindW-1:0]     kind_q;
  logic                          found_q;
  paq_pkg::entry_t               ret_q;
  logic [paq_pkg::CountW-1:0]    count_q;
  logic                          out_valid_q;
  logic                          out_found_q;
  paq_pkg::entry_t               out_entry_q;
  logic [paq_pkg::CountW-1:0]    out_count_q;

  logic            accept;
  logic            last;
  logic            seq_hit;
  logic            kind_hit;
  logic            drop;
  logic            pop_hit;
  paq_pkg::entry_t new_entry;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign idle_o     = (state_q == ST_IDLE);
  assign last       = (cnt_q == CntW'(MaxEntries - 1));
  assign pop_hit    = (func_i == paq_pkg::FUNC_POP) && head_live_i;

  assign new_entry   = '{call: call_flags_i, kind: alarm_kind_i, seq: seq_number_i};
  assign app_entry_o = new_entry;

  assign seq_hit  = head_live_i && (head_entry_i.seq == seq_q);
  assign kind_hit = head_live_i && (head_entry_i.kind == kind_q);

  // Only the oldest sequence match goes; every kind match goes.
  assign drop = (state_q == ST_SCAN) &&
                (((func_q == paq_pkg::FUNC_REM_SEQ) && seq_hit && !found_q) ||
                 ((func_q == paq_pkg::FUNC_REM_KIND) && kind_hit));

  // Tail feed: pushed entry on a full-table push, else the processed head.
  always_comb begin
    tail_entry_o = head_entry_i;
    tail_live_o  = 1'b0;
    if (accept) begin
      tail_entry_o = new_entry;
      tail_live_o  = (func_i == paq_pkg::FUNC_PUSH);
    end else if (state_q == ST_SCAN) begin
      tail_live_o = head_live_i && !drop;
    end
  end

  always_comb begin
    cell_ctl_o.mode   = paq_pkg::CELL_HOLD;
    cell_ctl_o.parity = cnt_q[0];
    if (accept) begin
      if (func_i == paq_pkg::FUNC_PUSH) begin
        cell_ctl_o.mode = full_i ? paq_pkg::CELL_SHIFT : paq_pkg::CELL_APPEND;
      end else if (func_i == paq_pkg::FUNC_POP) begin
        cell_ctl_o.mode = paq_pkg::CELL_SHIFT;
      end
    end else if (state_q == ST_SCAN) begin
      cell_ctl_o.mode = paq_pkg::CELL_SHIFT;
    end else if (state_q == ST_SORT) begin
      cell_ctl_o.mode = paq_pkg::CELL_SORT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Result leaves; in ST_DONE a new one may land in the same cycle.
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            func_q  <= func_i;
            seq_q   <= seq_number_i;
            kind_q  <= alarm_kind_i;
            cnt_q   <= '0;
            count_q <= '0;
            if ((func_i == paq_pkg::FUNC_REM_SEQ) || (func_i == paq_pkg::FUNC_REM_KIND) ||
                (func_i == paq_pkg::FUNC_COUNT)) begin
              found_q <= 1'b0;
              ret_q   <= '0;
              state_q <= ST_SCAN;
            end else begin
              found_q <= pop_hit;
              ret_q   <= pop_hit ? head_entry_i : '0;
              state_q <= ST_DONE;
            end
          end
        end
        ST_SCAN: begin
          if (drop && (func_q == paq_pkg::FUNC_REM_SEQ)) begin
            found_q <= 1'b1;
            ret_q   <= head_entry_i;
          end
          if (kind_hit && ((func_q == paq_pkg::FUNC_REM_KIND) ||
                           (func_q == paq_pkg::FUNC_COUNT))) begin
            count_q <= count_q + 1'b1;
          end
          if (last) begin
            cnt_q   <= '0;
            state_q <= (func_q == paq_pkg::FUNC_COUNT) ? ST_DONE : ST_SORT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_SORT: begin
          if (last) begin
            cnt_q   <= '0;
            state_q <= ST_DONE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_found_q <= found_q;
            out_entry_q <= ret_q;
            out_count_q <= count_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = out_found_q;
  assign entry_o       = out_entry_q;
  assign match_count_o = out_count_q;

endmodule

@@ hw/rtl/pending_alarm_queue.sv @@
// ----------------------------------------------------------------------------
// pending_alarm_queue
// Ordered table of outstanding alarm requests kept in a chain of cells,
// oldest entry at cell 0.
// ----------------------------------------------------------------------------
// Sequencing: push, remove-oldest and undefined codes go straight to the
//   result; count-by-kind makes one rotation pass first; remove-by-sequence
//   and remove-by-kind make two passes (one rotation pass, one compaction).
// Throughput: one request at a time, the next taken once the result is
//   registered (out_stall_i can hold it); passes move one cell per cycle.
// Reset: clears all live flags and the sequencer; entry data is not reset.
// ----------------------------------------------------------------------------
module pending_alarm_queue #(
  parameter int unsigned MaxEntries = 21
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [paq_pkg::FuncW-1:0]  func_i,
  input  logic [paq_pkg::SeqW-1:0]   seq_number_i,
  input  logic [paq_pkg::KindW-1:0]  alarm_kind_i,
  input  logic [paq_pkg::CallW-1:0]  call_flags_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       found_o,
  output logic [paq_pkg::SeqW-1:0]   entry_seq_o,
  output logic [paq_pkg::KindW-1:0]  entry_kind_o,
  output logic [paq_pkg::CallW-1:0]  entry_call_o,
  output logic [paq_pkg::CountW-1:0] match_count_o
);

  // Chain wiring. Each cell sees its upper neighbor (toward the tail) for
  // shifting and its lower neighbor's live flag for append and sort.
  paq_pkg::entry_t    cell_entry [MaxEntries];
  logic [MaxEntries-1:0] cell_live;

  paq_pkg::cell_ctl_t cell_ctl;
  paq_pkg::entry_t    tail_entry;
  logic               tail_live;
  paq_pkg::entry_t    app_entry;
  paq_pkg::entry_t    out_entry;
  logic               idle;

  for (genvar i = 0; i < MaxEntries; i++) begin : g_cell
    paq_pkg::entry_t up_entry;
    logic            up_live;
    logic            low_live;

    if (i == MaxEntries - 1) begin : g_top
      // Last cell is fed by the head processor during a rotation.
      assign up_entry = tail_entry;
      assign up_live  = tail_live;
    end else begin : g_mid
      assign up_entry = cell_entry[i+1];
      assign up_live  = cell_live[i+1];
    end

    if (i == 0) begin : g_head
      // Nothing below the head: behaves as an occupied neighbor.
      assign low_live = 1'b1;
    end else begin : g_low
      assign low_live = cell_live[i-1];
    end

    paq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (cell_ctl),
      .is_odd_i    ((i % 2) == 1),
      .app_entry_i (app_entry),
      .up_entry_i  (up_entry),
      .up_live_i   (up_live),
      .low_live_i  (low_live),
      .entry_o     (cell_entry[i]),
      .live_o      (cell_live[i])
    );
  end

  // Sequencer and head processor. The head entry is inspected once per
  // rotation step, so a full pass visits every entry in queue order.
  paq_ctrl #(
    .MaxEntries (MaxEntries)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .seq_number_i  (seq_number_i),
    .alarm_kind_i  (alarm_kind_i),
    .call_flags_i  (call_flags_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .found_o       (found_o),
    .entry_o       (out_entry),
    .match_count_o (match_count_o),
    .head_entry_i  (cell_entry[0]),
    .head_live_i   (cell_live[0]),
    .full_i        (cell_live[MaxEntries-1]),
    .cell_ctl_o    (cell_ctl),
    .tail_entry_o  (tail_entry),
    .tail_live_o   (tail_live),
    .app_entry_o   (app_entry),
    .idle_o        (idle)
  );

  assign entry_seq_o  = out_entry.seq;
  assign entry_kind_o = out_entry.kind;
  assign entry_call_o = out_entry.call;

  // Live flags form a solid run from the head whenever no request is active.
  logic live_packed;
  always_comb begin
    live_packed = 1'b1;
    for (int unsigned k = 0; k + 1 < MaxEntries; k++) begin
      if (cell_live[k+1] && !cell_live[k]) begin
        live_packed = 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_packed_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle |-> live_packed)
    else $error("queue has a hole while idle");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second request taken while one is active");

  a_found_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o) |-> (match_count_o == '0))
    else $error("entry returned together with a nonzero count");

  a_zero_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (out_entry == '0))
    else $error("entry fields nonzero without a returned entry");
`endif

endmodule

@@ tb/tb_pending_alarm_queue.sv @@
// ----------------------------------------------------------------------------
// tb_pending_alarm_queue
// Self-checking bench for the pending alarm queue. A shadow table predicts
// the reply to every accepted request; replies are checked in order, field
// by field. Directed tests cover empty-table requests, field extremes,
// duplicate keys and a full table. Random mixes then fill, drain, stall and
// burst the block.
// ----------------------------------------------------------------------------
module tb_pending_alarm_queue;

  localparam int unsigned TableDepth  = 21;
  localparam int          IdlePct     = 27;
  localparam int          CycleLimit  = 400000;
  localparam int          DrainCycles = 2 * TableDepth + 10;
  localparam int          HoldCycles  = 400;
  localparam int          MaxPrinted  = 40;

  typedef logic [paq_pkg::FuncW-1:0]  func_t;
  typedef logic [paq_pkg::SeqW-1:0]   seq_t;
  typedef logic [paq_pkg::KindW-1:0]  kind_t;
  typedef logic [paq_pkg::CallW-1:0]  call_t;
  typedef logic [paq_pkg::CountW-1:0] count_t;

  // Codes the block treats as no-ops
  localparam func_t FuncFirstUnused = 3'd5;
  localparam func_t FuncLastUnused  = 3'd7;

  typedef struct packed {
    logic   found;
    seq_t   seq;
    kind_t  kind;
    call_t  call;
    count_t count;
  } alarm_result_t;

  logic   clk_i;
  logic   rst_ni       = 1'b0;
  logic   in_valid_i   = 1'b0;
  logic   in_stall_o;
  func_t  func_i       = '0;
  seq_t   seq_number_i = '0;
  kind_t  alarm_kind_i = '0;
  call_t  call_flags_i = '0;
  logic   out_valid_o;
  logic   out_stall_i  = 1'b0;
  logic   found_o;
  seq_t   entry_seq_o;
  kind_t  entry_kind_o;
  call_t  entry_call_o;
  count_t match_count_o;

  pending_alarm_queue #(
    .MaxEntries(TableDepth)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .seq_number_i (seq_number_i),
    .alarm_kind_i (alarm_kind_i),
    .call_flags_i (call_flags_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .found_o      (found_o),
    .entry_seq_o  (entry_seq_o),
    .entry_kind_o (entry_kind_o),
    .entry_call_o (entry_call_o),
    .match_count_o(match_count_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Shadow copy of the table, oldest entry at index 0
  paq_pkg::entry_t shadow_table[$];
  alarm_result_t   predicted_results[$];

  int cycle_count  = 0;
  int err_count    = 0;
  int sent_count   = 0;
  int checked      = 0;
  int full_pushes  = 0;
  int seq_hits     = 0;
  int kind_removed = 0;

  // Traffic shaping shared by sender and receiver
  logic no_idle  = 1'b0;
  int   hold_gen = 0;
  int   hold_len = 0;
  int   hold_seen = 0;
  int   hold_left = 0;

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MaxPrinted) begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    end
  endtask

  // Apply one request to the shadow table and return the reply it causes
  function automatic alarm_result_t apply_request(input func_t func,
                                                  input seq_t  seq,
                                                  input kind_t kind,
                                                  input call_t call);
    alarm_result_t   r;
    paq_pkg::entry_t e;
    int              n;
    int              i;
    logic            hit;
    r   = '0;
    n   = 0;
    hit = 1'b0;
    case (func)
      paq_pkg::FUNC_PUSH: begin
        e.seq  = seq;
        e.kind = kind;
        e.call = call;
        if (shadow_table.size() >= TableDepth) begin
          void'(shadow_table.pop_front());
        end
        shadow_table.push_back(e);
      end
      paq_pkg::FUNC_REM_SEQ: begin
        // only the oldest match goes
        for (i = 0; i < shadow_table.size(); i++) begin
          if (!hit && shadow_table[i].seq == seq) begin
            hit     = 1'b1;
            r.found = 1'b1;
            r.seq   = shadow_table[i].seq;
            r.kind  = shadow_table[i].kind;
            r.call  = shadow_table[i].call;
            shadow_table.delete(i);
          end
        end
      end
      paq_pkg::FUNC_REM_KIND: begin
        i = 0;
        while (i < shadow_table.size()) begin
          if (shadow_table[i].kind == kind) begin
            shadow_table.delete(i);
            n++;
          end else begin
            i++;
          end
        end
      end
      paq_pkg::FUNC_POP: begin
        if (shadow_table.size() != 0) begin
          e       = shadow_table.pop_front();
          r.found = 1'b1;
          r.seq   = e.seq;
          r.kind  = e.kind;
          r.call  = e.call;
        end
      end
      paq_pkg::FUNC_COUNT: begin
        for (i = 0; i < shadow_table.size(); i++) begin
          if (shadow_table[i].kind == kind) n++;
        end
      end
      default: begin
      end
    endcase
    r.count = n[paq_pkg::CountW-1:0];
    return r;
  endfunction

  // Offer one request, hold it until accepted, then record its reply
  task automatic send_request(input func_t func, input seq_t seq,
                              input kind_t kind, input call_t call);
    alarm_result_t r;
    if (!no_idle) begin
      while ($urandom_range(99) < IdlePct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i   <= 1'b1;
    func_i       <= func;
    seq_number_i <= seq;
    alarm_kind_i <= kind;
    call_flags_i <= call;
    do begin
      @(posedge clk_i);
    end while (in_stall_o !== 1'b0);
    if (func == paq_pkg::FUNC_PUSH && shadow_table.size() >= TableDepth) full_pushes++;
    r = apply_request(func, seq, kind, call);
    if (func == paq_pkg::FUNC_REM_SEQ && r.found) seq_hits++;
    if (func == paq_pkg::FUNC_REM_KIND) kind_removed += r.count;
    predicted_results.push_back(r);
    sent_count++;
  endtask

  // Sender goes quiet until every reply is back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (predicted_results.size() != 0) @(posedge clk_i);
  endtask

  // Kinds: mostly live ones or a small pool so matches happen
  function automatic kind_t pick_kind();
    kind_t k;
    if (shadow_table.size() != 0 && $urandom_range(99) < 50) begin
      k = shadow_table[$urandom_range(shadow_table.size() - 1)].kind;
    end else if ($urandom_range(99) < 60) begin
      k = kind_t'($urandom_range(3));
    end else begin
      k = kind_t'($urandom_range(255));
    end
    return k;
  endfunction

  function automatic seq_t pick_seq(input int live_pct);
    seq_t s;
    if (shadow_table.size() != 0 && $urandom_range(99) < live_pct) begin
      s = shadow_table[$urandom_range(shadow_table.size() - 1)].seq;
    end else begin
      s = seq_t'($urandom_range(16'hFFFF));
    end
    return s;
  endfunction

  task automatic run_mix(input int n, input int push_pct);
    int    r;
    func_t f;
    repeat (n) begin
      if ($urandom_range(99) < push_pct) begin
        f = paq_pkg::FUNC_PUSH;
      end else begin
        r = $urandom_range(99);
        if (r < 30)      f = paq_pkg::FUNC_REM_SEQ;
        else if (r < 42) f = paq_pkg::FUNC_REM_KIND;
        else if (r < 72) f = paq_pkg::FUNC_POP;
        else if (r < 95) f = paq_pkg::FUNC_COUNT;
        else             f = func_t'($urandom_range(FuncLastUnused, FuncFirstUnused));
      end
      // pushes reuse a live sequence now and then to build duplicates
      send_request(f, pick_seq(f == paq_pkg::FUNC_PUSH ? 20 : 65), pick_kind(),
                   call_t'($urandom_range(255)));
    end
  endtask

  // ---- tests ---------------------------------------------------------------

  task automatic test_empty_table();
    send_request(paq_pkg::FUNC_POP, 16'h0000, 8'h00, 8'h00);
    send_request(paq_pkg::FUNC_REM_SEQ, 16'hFFFF, 8'h00, 8'h00);
    send_request(paq_pkg::FUNC_REM_KIND, 16'h0000, 8'hFF, 8'h00);
    send_request(paq_pkg::FUNC_COUNT, 16'h0000, 8'h00, 8'hFF);
    send_request(FuncFirstUnused, 16'hFFFF, 8'hFF, 8'hFF);
    send_request(FuncLastUnused, 16'hA5A5, 8'h5A, 8'hC3);
  endtask

  task automatic test_fields_and_duplicates();
    send_request(paq_pkg::FUNC_PUSH, 16'h0000, 8'h00, 8'h00);
    send_request(paq_pkg::FUNC_PUSH, 16'hFFFF, 8'hFF, 8'hFF);
    send_request(paq_pkg::FUNC_PUSH, 16'h1234, 8'hFF, 8'h5A);
    send_request(paq_pkg::FUNC_PUSH, 16'hFFFF, 8'h01, 8'hA5);
    send_request(paq_pkg::FUNC_COUNT, 16'h0000, 8'hFF, 8'h00);
    // duplicate sequence: oldest copy leaves first
    send_request(paq_pkg::FUNC_REM_SEQ, 16'hFFFF, 8'h00, 8'h00);
    send_request(paq_pkg::FUNC_REM_SEQ, 16'h4321, 8'h00, 8'h00);
    send_request(paq_pkg::FUNC_REM_KIND, 16'h0000, 8'hFF, 8'h00);
    send_request(paq_pkg::FUNC_REM_KIND, 16'h0000, 8'h07, 8'h00);
    send_request(paq_pkg::FUNC_POP, 16'h0000, 8'h00, 8'h00);
    send_request(paq_pkg::FUNC_POP, 16'h0000, 8'h00, 8'h00);
    send_request(paq_pkg::FUNC_POP, 16'h0000, 8'h00, 8'h00);
  endtask

  task automatic test_full_table();
    int i;
    // two pushes past full drop the two oldest entries
    for (i = 0; i < TableDepth + 2; i++) begin
      send_request(paq_pkg::FUNC_PUSH, 16'(100 + i), 8'(i % 3), 8'(8'hF0 ^ i));
    end
    send_request(paq_pkg::FUNC_COUNT, 16'h0000, 8'h00, 8'h00);
    send_request(paq_pkg::FUNC_REM_SEQ, 16'd101, 8'h00, 8'h00);
    send_request(paq_pkg::FUNC_POP, 16'h0000, 8'h00, 8'h00);
  endtask

  task automatic test_random_fill();
    run_mix(200, 70);
  endtask

  task automatic test_random_drain();
    run_mix(150, 25);
  endtask

  task automatic test_no_idle_stretch();
    no_idle <= 1'b1;
    run_mix(150, 50);
    no_idle <= 1'b0;
  endtask

  // Receiver holds off while the sender keeps offering requests
  task automatic test_receiver_hold();
    hold_len <= HoldCycles;
    hold_gen <= hold_gen + 1;
    run_mix(40, 60);
  endtask

  task automatic test_sender_pause();
    repeat (3) begin
      run_mix(20, 55);
      wait_drained();
    end
  endtask

  // ---- receiver: random stalls, long hold on request ----------------------
  always @(posedge clk_i) begin
    if (hold_gen != hold_seen) begin
      hold_seen   <= hold_gen;
      hold_left   <= hold_len;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (no_idle) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < IdlePct);
    end
  end

  // ---- reply checker -------------------------------------------------------
  always @(posedge clk_i) begin
    alarm_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      checked++;
      if (predicted_results.size() == 0) begin
        report_mismatch("reply with no request outstanding");
      end else begin
        want = predicted_results.pop_front();
        if (found_o !== want.found)
          report_mismatch($sformatf("found %b, want %b", found_o, want.found));
        if (entry_seq_o !== want.seq)
          report_mismatch($sformatf("entry_seq %h, want %h", entry_seq_o, want.seq));
        if (entry_kind_o !== want.kind)
          report_mismatch($sformatf("entry_kind %h, want %h", entry_kind_o, want.kind));
        if (entry_call_o !== want.call)
          report_mismatch($sformatf("entry_call %h, want %h", entry_call_o, want.call));
        if (match_count_o !== want.count)
          report_mismatch($sformatf("match_count %0d, want %0d", match_count_o, want.count));
      end
    end
  end

  // ---- watchdog ------------------------------------------------------------
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_fields_and_duplicates();
    test_full_table();
    test_random_fill();
    test_receiver_hold();
    test_random_drain();
    test_no_idle_stretch();
    test_sender_pause();

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (predicted_results.size() != 0) begin
      report_mismatch($sformatf("%0d replies never arrived", predicted_results.size()));
    end

    $display("run covered %0d requests, %0d replies checked, %0d mismatches",
             sent_count, checked, err_count);
    $display("pushes into full table %0d, sequence hits %0d, removed by kind %0d",
             full_pushes, seq_hits, kind_removed);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/paq_pkg.sv
hw/rtl/paq_cell.sv
hw/rtl/paq_ctrl.sv
hw/rtl/pending_alarm_queue.sv
tb/tb_pending_alarm_queue.sv
